### rtl/core/sorted_set_engine_core_defines.svh
// assertion macros for the sorted set engine
`ifndef SORTED_SET_ENGINE_CORE_DEFINES_SVH
`define SORTED_SET_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/sse_pkg.sv
`timescale 1ns / 1ps
package sse_pkg;

	localparam int KEY_FIELD_W   = 16;
	localparam int COUNT_FIELD_W = 7;

	// operation codes
	localparam logic [1:0] OP_MEMBER = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	typedef struct packed {
		logic [1:0]             op;
		logic [KEY_FIELD_W-1:0] key;
	} sse_in_t;

	typedef struct packed {
		logic                     success;
		logic                     full_reject;
		logic [COUNT_FIELD_W-1:0] count;
	} sse_out_t;

	// update strobes broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} sse_cell_ctl_t;

endpackage

### rtl/core/sse_cell.sv
`timescale 1ns / 1ps
module sse_cell #(
	parameter int KW  = 16,
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  cap,
	input  sse_pkg::sse_cell_ctl_t ctl,
	input  logic [KW-1:0]         cmp_key,
	input  logic [KW-1:0]         upd_key,
	input  logic [CW-1:0]         count,
	input  logic                  prev_lt,
	input  logic [KW-1:0]         prev_key,
	input  logic [KW-1:0]         next_key,
	output logic [KW-1:0]         key_q,
	output logic                  lt_s1,
	output logic                  eq_s1
);
	import sse_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic occ;

	assign occ = (IDX_C < count);

	// compare stage: this slot against the incoming key
	always_ff @(posedge clk) begin
		if (cap) begin
			lt_s1 <= occ && (key_q < cmp_key);
			eq_s1 <= occ && (key_q == cmp_key);
		end
	end

	// shift stage: open a gap at the insert point or close it on delete
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!prev_lt) begin
				key_q <= prev_key;
			end else if (!lt_s1) begin
				key_q <= upd_key;
			end
		end else if (ctl.del) begin
			if (!lt_s1) begin
				key_q <= next_key;
			end
		end
	end

endmodule

### rtl/core/sorted_set_engine_core.sv
// sorted set engine: a set of distinct keys held in ascending order in a
// row of compare-and-shift cells, one key per cell.
// request channel (req_valid / req_stall / req): one transaction carries an
// op (member, insert, delete) and a key; only the low KEY_BITS bits of the
// key take part.
// response channel (rsp_valid / rsp_stall / rsp): exactly one transaction per
// request, in request order, with success, full_reject and the key count
// after the operation.
// a taken request is compared against every cell into the compare stage;
// once the output register is free the row shifts, the count updates and
// the response is registered. no new request is taken in the meantime.
// req_stall is high while a request sits in the compare stage.
// a stalled response holds in the output register; the next request is
// still taken and waits in the compare stage until that register frees up.
// reset empties the set (count zero); cell contents need no clearing since
// slots at or above the count are never used.
`timescale 1ns / 1ps
module sorted_set_engine_core #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sse_pkg::sse_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sse_pkg::sse_out_t rsp
);
	import sse_pkg::*;

	// stored key width: the request field caps it
	localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]       cnt_q;
	logic                s1_vld_q;
	logic [1:0]          op_s1;
	logic [KW-1:0]       key_s1;
	logic                rsp_valid_q;
	sse_out_t            rsp_q;

	logic [KW-1:0]       key_vec [CAPACITY];
	logic [CAPACITY-1:0] lt_vec;
	logic [CAPACITY-1:0] eq_vec;

	logic                req_acc;
	logic                out_free;
	logic                fire;
	logic                found;
	logic                full;
	logic                ins_en;
	logic                del_en;
	logic [CW-1:0]       cnt_next;
	sse_cell_ctl_t       ctl;

	// one request in flight at a time
	assign req_stall = s1_vld_q;
	assign req_acc   = req_valid && !req_stall;

	// output register frees when empty or being drained this cycle
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign fire     = s1_vld_q && out_free;

	assign found  = |eq_vec;
	assign full   = (cnt_q == CW'(CAPACITY));
	assign ins_en = (op_s1 == OP_INSERT) && !found && !full;
	assign del_en = (op_s1 == OP_DELETE) && found;

	assign ctl.ins = fire && ins_en;
	assign ctl.del = fire && del_en;

	always_comb begin
		cnt_next = cnt_q;
		if (ins_en) begin
			cnt_next = cnt_q + CW'(1);
		end else if (del_en) begin
			cnt_next = cnt_q - CW'(1);
		end
	end

	// row of cells; cell i holds the i-th smallest key
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic          prev_lt;
		logic [KW-1:0] prev_key;
		logic [KW-1:0] next_key;

		if (g == 0) begin : g_first
			assign prev_lt  = 1'b1;
			assign prev_key = key_s1;
		end else begin : g_mid
			assign prev_lt  = lt_vec[g-1];
			assign prev_key = key_vec[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign next_key = key_vec[g];
		end else begin : g_inner
			assign next_key = key_vec[g+1];
		end

		sse_cell #(
			.KW  (KW),
			.CW  (CW),
			.IDX (g)
		) u_cell (
			.clk      (clk),
			.cap      (req_acc),
			.ctl      (ctl),
			.cmp_key  (req.key[KW-1:0]),
			.upd_key  (key_s1),
			.count    (cnt_q),
			.prev_lt  (prev_lt),
			.prev_key (prev_key),
			.next_key (next_key),
			.key_q    (key_vec[g]),
			.lt_s1    (lt_vec[g]),
			.eq_s1    (eq_vec[g])
		);
	end

	// compare stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (req_acc) begin
			s1_vld_q <= 1'b1;
		end else if (fire) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_s1  <= req.op;
			key_s1 <= req.key[KW-1:0];
		end
	end

	// key count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_next;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.success     <= ((op_s1 == OP_MEMBER) && found) || ins_en || del_en;
			rsp_q.full_reject <= (op_s1 == OP_INSERT) && !found && full;
			rsp_q.count       <= COUNT_FIELD_W'(cnt_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/sse_checker.sv
`timescale 1ns / 1ps
`include "sorted_set_engine_core_defines.svh"
module sse_checker #(
	parameter int CAPACITY = 64
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input sse_pkg::sse_out_t rsp
);
	import sse_pkg::*;

	localparam logic [COUNT_FIELD_W-1:0] CAP_C = COUNT_FIELD_W'(CAPACITY);

	logic req_acc;

	assign req_acc = req_valid && !req_stall;

	// a refused insert means the set is at capacity
	`SSE_ASSERT_NOW(a_reject_full, rsp_valid && rsp.full_reject, rsp.count == CAP_C, "reject below capacity")

	// a refused insert never reports success
	`SSE_ASSERT_NOW(a_reject_no_success, rsp_valid && rsp.full_reject, !rsp.success, "reject with success")

	// the compare stage holds one request, so a second cannot follow at once
	`SSE_ASSERT_NEXT(a_one_in_flight, req_acc, req_stall, "request taken while busy")

	// a stalled response holds
	`SSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind sorted_set_engine_core sse_checker #(
	.CAPACITY (CAPACITY)
) u_sse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// check of the sorted set engine: a directed table of transactions, then random
// workloads (fill to capacity, churn on a narrow key range, drain, noise), all
// checked against a queue-based copy of the ordered key set, but typed table rows against the table itself
module tb_top;
	import sse_pkg::*;

	localparam int SET_CAPACITY = 64;
	localparam int ITEM_TARGET  = 1450;

	// op code the engine must treat as a no-op
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum int {WL_FILL, WL_CHURN, WL_DRAIN, WL_NOISE} workload_e;

	// one row of the directed table; typed rows carry their own expected result
	typedef struct {
		sse_in_t  item;
		bit       typed;
		sse_out_t want;
	} table_row_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	sse_in_t  req;
	logic     rsp_valid;
	logic     rsp_stall;
	sse_out_t rsp;

	// keys the engine should hold, ascending
	logic [KEY_FIELD_W-1:0] held_keys[$];
	// results still owed by the engine, oldest first
	sse_out_t pending_results[$];
	int fail_cnt = 0;
	// request transactions taken, op codes that do nothing not counted
	int sent_cnt = 0;
	// sender skips its idle gaps while this is set
	bit req_rush = 1'b0;

	sorted_set_engine_core #(
		.CAPACITY(SET_CAPACITY),
		.KEY_BITS(KEY_FIELD_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// apply one operation to the held set and return the result it should give
	function automatic sse_out_t apply_to_set(sse_in_t item);
		int       pos;
		bit       hit;
		sse_out_t res;
		pos = 0;
		while (pos < held_keys.size() && held_keys[pos] < item.key)
			pos++;
		hit = (pos < held_keys.size()) && (held_keys[pos] == item.key);
		res = '0;
		case (item.op)
			OP_MEMBER: begin
				res.success = hit;
			end
			OP_INSERT: begin
				// a held key is neither added nor rejected, even when full
				if (!hit) begin
					if (held_keys.size() >= SET_CAPACITY) begin
						res.full_reject = 1'b1;
					end else begin
						held_keys.insert(pos, item.key);
						res.success = 1'b1;
					end
				end
			end
			OP_DELETE: begin
				if (hit) begin
					held_keys.delete(pos);
					res.success = 1'b1;
				end
			end
			default: begin
				// unused op code leaves the set alone
			end
		endcase
		res.count = COUNT_FIELD_W'(held_keys.size());
		return res;
	endfunction

	function automatic table_row_t plain_row(logic [1:0] op, logic [KEY_FIELD_W-1:0] key);
		table_row_t row;
		row.item.op  = op;
		row.item.key = key;
		row.typed    = 1'b0;
		row.want     = '0;
		return row;
	endfunction

	function automatic table_row_t typed_row(logic [1:0] op, logic [KEY_FIELD_W-1:0] key,
		logic success, logic full_reject, int count);
		table_row_t row;
		row = plain_row(op, key);
		row.typed            = 1'b1;
		row.want.success     = success;
		row.want.full_reject = full_reject;
		row.want.count       = COUNT_FIELD_W'(count);
		return row;
	endfunction

	// held keys and their neighbors in a share set by held_pct, some extremes, the rest fresh
	function automatic logic [KEY_FIELD_W-1:0] pick_key(int held_pct, bit narrow);
		int                     r;
		logic [KEY_FIELD_W-1:0] k;
		r = $urandom_range(0, 99);
		if (held_keys.size() > 0 && r < held_pct + 10) begin
			k = held_keys[$urandom_range(0, held_keys.size() - 1)];
			if (r >= held_pct)
				k = $urandom_range(0, 1) ? k + 1'b1 : k - 1'b1;
			return k;
		end
		if (r < held_pct + 15)
			return $urandom_range(0, 1) ? '0 : '1;
		if (narrow)
			return KEY_FIELD_W'($urandom_range(0, 95));
		return KEY_FIELD_W'($urandom);
	endfunction

	// drive one request transaction; the expectation is queued at the edge that takes it
	task automatic send_item(input sse_in_t item, input bit typed, input sse_out_t want);
		int       gap;
		sse_out_t predicted;
		gap = req_rush ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		predicted = apply_to_set(item);
		// typed rows check the engine against the table itself
		pending_results.push_back(typed ? want : predicted);
		if (item.op != OP_UNUSED)
			sent_cnt++;
	endtask

	// hold off the sender until every owed result has come back
	task automatic wait_all_results();
		req_valid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
	endtask

	task automatic run_workload(input workload_e wl);
		int      n;
		int      r;
		sse_in_t item;
		case (wl)
			WL_FILL:  n = SET_CAPACITY - held_keys.size() + $urandom_range(4, 12);
			WL_CHURN: n = $urandom_range(50, 100);
			WL_DRAIN: n = held_keys.size() + $urandom_range(2, 8);
			default:  n = $urandom_range(10, 30);
		endcase
		req_rush = ($urandom_range(0, 3) == 0);
		repeat (n) begin
			r = $urandom_range(0, 99);
			case (wl)
				WL_FILL: begin
					// push past capacity so new keys get rejected
					item.op  = (r < 88) ? OP_INSERT : (r < 96) ? OP_MEMBER : OP_DELETE;
					item.key = pick_key(15, 1'b0);
				end
				WL_CHURN: begin
					// narrow range keeps hits frequent and count near capacity
					item.op  = (r < 40) ? OP_INSERT : (r < 75) ? OP_DELETE :
						(r < 98) ? OP_MEMBER : OP_UNUSED;
					item.key = pick_key(40, 1'b1);
				end
				WL_DRAIN: begin
					item.op  = (r < 85) ? OP_DELETE : OP_MEMBER;
					item.key = pick_key(90, 1'b0);
				end
				default: begin
					item.op  = 2'($urandom_range(OP_MEMBER, OP_UNUSED));
					item.key = KEY_FIELD_W'($urandom);
				end
			endcase
			send_item(item, 1'b0, '0);
		end
	endtask

	function automatic void compare_field(string name, logic [6:0] want, logic [6:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_cnt++;
		end
	endfunction

	// stimulus
	initial begin
		table_row_t table_rows[$];
		workload_e  wl;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		table_rows = '{
			// empty set right after reset
			typed_row(OP_MEMBER, 16'h0000, 1'b0, 1'b0, 0),
			typed_row(OP_DELETE, 16'h0000, 1'b0, 1'b0, 0),
			typed_row(OP_INSERT, 16'h0000, 1'b1, 1'b0, 1),
			// insert of a key already held
			typed_row(OP_INSERT, 16'h0000, 1'b0, 1'b0, 1),
			typed_row(OP_INSERT, 16'hffff, 1'b1, 1'b0, 2),
			typed_row(OP_MEMBER, 16'hffff, 1'b1, 1'b0, 2),
			typed_row(OP_MEMBER, 16'h0000, 1'b1, 1'b0, 2),
			// unused op code, both key extremes
			typed_row(OP_UNUSED, 16'hffff, 1'b0, 1'b0, 2),
			typed_row(OP_UNUSED, 16'h0000, 1'b0, 1'b0, 2),
			typed_row(OP_MEMBER, 16'h8000, 1'b0, 1'b0, 2),
			// inserts landing in the middle and next to the ends
			plain_row(OP_INSERT, 16'h8000),
			plain_row(OP_INSERT, 16'h7fff),
			plain_row(OP_INSERT, 16'h0001),
			plain_row(OP_INSERT, 16'hfffe),
			plain_row(OP_MEMBER, 16'h7fff),
			plain_row(OP_MEMBER, 16'h7ffe),
			// delete in the middle, then the same key absent
			plain_row(OP_DELETE, 16'h8000),
			plain_row(OP_DELETE, 16'h8000),
			plain_row(OP_INSERT, 16'haaaa),
			plain_row(OP_INSERT, 16'h5555),
			// deletes at head and tail
			plain_row(OP_DELETE, 16'h0000),
			plain_row(OP_DELETE, 16'hffff),
			plain_row(OP_MEMBER, 16'h5555),
			plain_row(OP_DELETE, 16'haaaa)
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i])
			send_item(table_rows[i].item, table_rows[i].typed, table_rows[i].want);
		// full stop of the sender at least once
		wait_all_results();
		// start from a fill so the full-store cases come early
		run_workload(WL_FILL);
		while (sent_cnt < ITEM_TARGET) begin
			wl = workload_e'($urandom_range(WL_FILL, WL_NOISE));
			run_workload(wl);
			if ($urandom_range(0, 3) == 0)
				wait_all_results();
		end
		wait_all_results();
		// keep running after the last owed result to catch stray responses
		repeat (8) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// response side: random stall before each transaction, with stall-free stretches
	initial begin
		int       hold;
		int       left;
		bit       rsp_rush;
		sse_out_t want;
		left      = 0;
		rsp_rush  = 1'b0;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (left == 0) begin
				rsp_rush = ($urandom_range(0, 3) == 0);
				left     = $urandom_range(20, 80);
			end
			left--;
			hold = rsp_rush ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			if (pending_results.size() == 0) begin
				$display("%0t: response with nothing expected, actual %p", $time, rsp);
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				compare_field("success", 7'(want.success), 7'(rsp.success));
				compare_field("full_reject", 7'(want.full_reject), 7'(rsp.full_reject));
				compare_field("count", want.count, rsp.count);
			end
		end
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
